@@ sv/mdt_pkg.sv @@
// Shared types and constants for the multi-delimiter tokenizer.
package mdt_pkg;

   // Field and register widths fixed by the interface.
   localparam int BYTE_W       = 8;
   localparam int DELIM_W      = 64;
   localparam int LEN_W        = 4;
   localparam int TOKEN_OFS_W  = 32;
   localparam int CSR_INDEX_W  = 3;
   localparam int RSP_DATA_W   = 2 * TOKEN_OFS_W;

   // Maximum number of delimiter slots the register map provides.
   localparam int MAX_SLOTS    = 4;

   typedef logic [BYTE_W-1:0]  octet_type;
   typedef logic [DELIM_W-1:0] delim_type;
   typedef logic [LEN_W-1:0]   len_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DELIM0_BYTES = 3'd0,
      CSR_DELIM1_BYTES = 3'd1,
      CSR_DELIM2_BYTES = 3'd2,
      CSR_DELIM3_BYTES = 3'd3,
      CSR_DELIM0_LEN   = 3'd4,
      CSR_DELIM1_LEN   = 3'd5,
      CSR_DELIM2_LEN   = 3'd6,
      CSR_DELIM3_LEN   = 3'd7
   } csr_index_type;

endpackage

@@ sv/multi_delimiter_tokenizer.sv @@
// Top level of the multi-delimiter tokenizer: stream ports, state and result register.
// The block accepts one document byte per clock cycle while results are taken and splits the
// document at any of up to four configured delimiter strings of 1 to 8 bytes; each non-empty
// token gives one result holding its start offset and the offset just past its end. Every item
// passes through an input register and a result register; a result is loaded as its item leaves
// the input register, and a new item is taken every cycle as long as results are being taken;
// throughput is set by the single compare stage between those two registers. The item with tlast
// set ends the document, and the next item starts a new document at offset 0. The user must write
// delimiter registers through the csr port only while no item is in flight; the block does not check it.
module multi_delimiter_tokenizer #(
   parameter int NUM_DELIMS    = 4,
   parameter int MAX_DELIM_LEN = 8,
   parameter int OFFSET_BITS   = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input channel.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [mdt_pkg::BYTE_W-1:0]            req_tdata,  // [7:0] data_byte
   input  logic                                  req_tlast,  // doc_end
   // Result channel.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [mdt_pkg::RSP_DATA_W-1:0]        rsp_tdata,  // [31:0] token_start, [63:32] token_end
   // Configuration port.
   input  logic                                  csr_we,
   input  logic [mdt_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [mdt_pkg::DELIM_W-1:0]           csr_wdata
);

   localparam int WIN_W = MAX_DELIM_LEN * mdt_pkg::BYTE_W;
   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

   // Delimiter registers.
   mdt_pkg::delim_type delim_bytes_ff [NUM_DELIMS];
   mdt_pkg::len_type   delim_len_ff   [NUM_DELIMS];

   // Input register.
   logic               s1_valid_ff;
   mdt_pkg::octet_type s1_byte_ff;
   logic               s1_last_ff;
   logic               s1_adv;

   // Document state.
   logic [WIN_W-1:0]            hist_ff;
   logic [WIN_W-1:0]            hist_in;
   logic [OFFSET_BITS-1:0]      pos_ff;
   logic [OFFSET_BITS-1:0]      pos_in;
   logic [OFFSET_BITS-1:0]      tok_start_ff;
   logic [OFFSET_BITS-1:0]      tok_start_in;
   logic [mdt_pkg::LEN_W-1:0]   restart_cnt_ff;
   logic [mdt_pkg::LEN_W-1:0]   restart_cnt_in;

   // Result register.
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [mdt_pkg::TOKEN_OFS_W-1:0] rsp_start_ff;
   logic [mdt_pkg::TOKEN_OFS_W-1:0] rsp_end_ff;

   // Compare stage signals.
   logic [WIN_W+mdt_pkg::BYTE_W-1:0] win_wide;
   logic [WIN_W-1:0]                 window;
   mdt_pkg::len_type                 best_len;
   logic [OFFSET_BITS-1:0]           after;
   logic [OFFSET_BITS-1:0]           back;
   logic [OFFSET_BITS-1:0]           tok_end;
   logic                             hit;
   logic [63:0]                      start_ext;
   logic [63:0]                      end_ext;

   // Configuration writes; slots beyond NUM_DELIMS are not stored.
   for (genvar g = 0; g < NUM_DELIMS; g++) begin : g_cfg
      always_ff @(posedge clock) begin
         if (reset) begin
            delim_bytes_ff[g] <= '0;
            delim_len_ff[g]   <= '0;
         end else if (csr_we) begin
            if (csr_index == mdt_pkg::CSR_INDEX_W'(int'(mdt_pkg::CSR_DELIM0_BYTES) + g)) begin
               delim_bytes_ff[g] <= csr_wdata;
            end
            if (csr_index == mdt_pkg::CSR_INDEX_W'(int'(mdt_pkg::CSR_DELIM0_LEN) + g)) begin
               delim_len_ff[g] <= csr_wdata[mdt_pkg::LEN_W-1:0];
            end
         end
      end
   end

   // Current byte followed by the earlier bytes of the document, most recent first.
   assign win_wide = {hist_ff, s1_byte_ff};
   assign window   = win_wide[WIN_W-1:0];

   mdt_match #(
      .NUM_DELIMS    (NUM_DELIMS),
      .MAX_DELIM_LEN (MAX_DELIM_LEN)
   ) u_match (
      .window        (window),
      .delim_bytes   (delim_bytes_ff),
      .delim_len     (delim_len_ff),
      .since_restart (restart_cnt_ff),
      .best_len      (best_len)
   );

   // Token boundaries for the item in the input register.
   always_comb begin
      after   = (pos_ff == OFFSET_MAX) ? pos_ff : pos_ff + 1'b1;
      back    = OFFSET_BITS'(best_len) - 1'b1;
      tok_end = after;
      hit     = 1'b0;
      if (best_len != '0) begin
         tok_end = (pos_ff >= back) ? pos_ff - back : '0;
         hit     = tok_end > tok_start_ff;
      end else begin
         hit     = s1_last_ff && (after > tok_start_ff);
      end
      start_ext = 64'(tok_start_ff);
      end_ext   = 64'(tok_end);
   end

   // The item moves on unless it has a result and the result register is still full.
   assign s1_adv     = s1_valid_ff && (!hit || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;

   // Next document state.
   always_comb begin
      hist_in        = hist_ff;
      pos_in         = pos_ff;
      tok_start_in   = tok_start_ff;
      restart_cnt_in = restart_cnt_ff;
      if (s1_adv) begin
         if (best_len != '0) begin
            tok_start_in   = after;
            restart_cnt_in = '0;
         end else if (restart_cnt_ff != '1) begin
            restart_cnt_in = restart_cnt_ff + 1'b1;
         end
         if (s1_last_ff) begin
            pos_in         = '0;
            tok_start_in   = '0;
            restart_cnt_in = '0;
         end else begin
            hist_in = win_wide[WIN_W-1:0];
            pos_in  = after;
         end
      end
   end

   // Result valid: loaded by a token, cleared when taken.
   always_comb begin
      if (s1_adv && hit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         pos_ff         <= '0;
         tok_start_ff   <= '0;
         restart_cnt_ff <= '0;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         rsp_valid_ff   <= rsp_valid_in;
         pos_ff         <= pos_in;
         tok_start_ff   <= tok_start_in;
         restart_cnt_ff <= restart_cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      hist_ff <= hist_in;
      if (req_tready && req_tvalid) begin
         s1_byte_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
      if (s1_adv && hit) begin
         rsp_start_ff <= start_ext[mdt_pkg::TOKEN_OFS_W-1:0];
         rsp_end_ff   <= end_ext[mdt_pkg::TOKEN_OFS_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_end_ff, rsp_start_ff};

endmodule

@@ sv/mdt_match.sv @@
// Parallel delimiter compare: length of the longest delimiter ending at the current byte.
module mdt_match #(
   parameter int NUM_DELIMS    = 4,
   parameter int MAX_DELIM_LEN = 8
) (
   input  logic [MAX_DELIM_LEN*mdt_pkg::BYTE_W-1:0] window,
   input  mdt_pkg::delim_type                      delim_bytes [NUM_DELIMS],
   input  mdt_pkg::len_type                        delim_len   [NUM_DELIMS],
   input  logic [mdt_pkg::LEN_W-1:0]               since_restart,
   output mdt_pkg::len_type                        best_len
);

   // Per delimiter and per candidate length: do the bytes line up with the window?
   logic [MAX_DELIM_LEN:1] eq [NUM_DELIMS];
   logic [NUM_DELIMS-1:0]  hit;

   // Window byte at distance 'back' before the current byte must equal
   // delimiter byte k, where back = length - 1 - k.
   always_comb begin
      for (int i = 0; i < NUM_DELIMS; i++) begin
         for (int l = 1; l <= MAX_DELIM_LEN; l++) begin
            eq[i][l] = 1'b1;
            for (int k = 0; k < l; k++) begin
               if (window[(l-1-k)*mdt_pkg::BYTE_W +: mdt_pkg::BYTE_W] !=
                   delim_bytes[i][k*mdt_pkg::BYTE_W +: mdt_pkg::BYTE_W]) begin
                  eq[i][l] = 1'b0;
               end
            end
         end
      end
   end

   // A delimiter counts when its length is in range, fits inside the bytes
   // seen since the last restart and its compare succeeds.
   always_comb begin
      for (int i = 0; i < NUM_DELIMS; i++) begin
         hit[i] = 1'b0;
         for (int l = 1; l <= MAX_DELIM_LEN; l++) begin
            if ((delim_len[i] == mdt_pkg::LEN_W'(l)) &&
                (mdt_pkg::LEN_W'(l - 1) <= since_restart) && eq[i][l]) begin
               hit[i] = 1'b1;
            end
         end
      end
   end

   // Longest matching delimiter wins.
   always_comb begin
      best_len = '0;
      for (int i = 0; i < NUM_DELIMS; i++) begin
         if (hit[i] && (delim_len[i] > best_len)) begin
            best_len = delim_len[i];
         end
      end
   end

endmodule
